### design/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg: shared definitions for the perspective projection block
// Register indexes, reset values and field widths of the world-to-screen
// projection pipeline.
// ----------------------------------------------------------------------------
package ppts_pkg;

  // Default number of fractional bits of the fixed-point coordinates.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned IN_DATA_W = 3 * COORD_W;
  localparam int unsigned OUT_DATA_W = 2 * PIX_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned DEPTH_W    = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH = 3'd7;

  // Register reset values: identity-like rows, a 1920x1080 window.
  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_LO = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_X_HI = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_LO = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_Y_HI = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_LO = 64'h0000_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_ROW_W_HI = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_VIEWPORT = 64'h0438_0780_0000_0000;
  localparam logic [DEPTH_W-1:0]    RST_MIN_DEPTH = 16'd655;

  // Quotient bits resolved by the divider; anything larger saturates.
  localparam int unsigned QUOT_W = PIX_W;

endpackage

### design/perspective_projection_to_screen.sv
// ----------------------------------------------------------------------------
// perspective_projection_to_screen: world point to screen pixel
// Transforms a world point by three rows of a view matrix, culls points
// closer than the minimum depth and maps the rest to saturated pixel positions.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one world point per request (x, y, z in signed
//   fixed point). The master stream returns one result per request: the
//   screen column and row in tdata and the visible flag in tuser. Results
//   leave in request order.
//   From acceptance to the master side, a request passes through
//   six stages for the matrix products, clip sums, numerator products,
//   numerator sums, magnitudes and the range check, then one stage per
//   quotient bit in the 16-stage divider, then the output register.
//   Throughput is one point per cycle unless all stages are full and the
//   receiver stalls; every stage holds one request. When the receiver stalls,
//   the last stage holds its result and requests behind it close up into
//   empty stages; s_axis_tready_o drops only when all stages are full.
//   Reset empties the pipeline and loads the default matrix rows, viewport
//   and minimum depth. The user must write the configuration port only while
//   the pipeline is empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module perspective_projection_to_screen #(
  parameter int unsigned FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [ppts_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [ppts_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // World point stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: world_x [31:0], world_y [63:32], world_z [95:64]
  input  logic [ppts_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // Screen position stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: screen_x [15:0], screen_y [31:16]
  output logic [ppts_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // tuser: visible [0]
  output logic [0:0]                        m_axis_tuser_o
);
  import ppts_pkg::*;

  // Derived widths.
  localparam int unsigned SUM_W  = 2 * COORD_W + 2;
  localparam int unsigned CLIP_W = SUM_W - FRAC_BITS;
  localparam int unsigned MUL_W  = CLIP_W + 19;
  localparam int unsigned NUM_W  = MUL_W + 1;
  localparam int unsigned DEN_W  = CLIP_W;
  localparam int unsigned RW     = DEN_W + QUOT_W;

  // Pipeline stage positions.
  localparam int unsigned ST_MUL   = 0;
  localparam int unsigned ST_CLIP  = 1;
  localparam int unsigned ST_PROJ  = 2;
  localparam int unsigned ST_SUM   = 3;
  localparam int unsigned ST_ABS   = 4;
  localparam int unsigned ST_RANGE = 5;
  localparam int unsigned ST_DIV0  = 6;
  localparam int unsigned ST_OUT   = ST_DIV0 + QUOT_W;
  localparam int unsigned N_ST     = ST_OUT + 1;

  // State carried through the divider stages.
  typedef struct packed {
    logic             vis;
    logic             neg_x;
    logic             neg_y;
    logic             big_x;
    logic             big_y;
    logic [DEN_W-1:0] den;
    logic [RW-1:0]    rem_x;
    logic [RW-1:0]    rem_y;
    logic [QUOT_W-1:0] q_x;
    logic [QUOT_W-1:0] q_y;
  } div_t;

  // Saturate a truncated quotient magnitude to a signed pixel.
  function automatic logic signed [PIX_W-1:0] sat_pix(input logic neg, input logic big,
                                                      input logic [QUOT_W-1:0] q);
    logic signed [PIX_W-1:0] res;
    if (neg) begin
      if (big || q > 16'd32768) res = 16'sh8000;
      else res = $signed(16'd0 - q);
    end else begin
      if (big || q > 16'd32767) res = 16'sh7fff;
      else res = $signed(q);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] row_lo_q [0:2];
  logic [CFG_DATA_W-1:0] row_hi_q [0:2];
  logic [CFG_DATA_W-1:0] viewport_q;
  logic [DEPTH_W-1:0]    min_depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_lo_q[0] <= RST_ROW_X_LO;
      row_hi_q[0] <= RST_ROW_X_HI;
      row_lo_q[1] <= RST_ROW_Y_LO;
      row_hi_q[1] <= RST_ROW_Y_HI;
      row_lo_q[2] <= RST_ROW_W_LO;
      row_hi_q[2] <= RST_ROW_W_HI;
      viewport_q  <= RST_VIEWPORT;
      min_depth_q <= RST_MIN_DEPTH;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ROW_X_LO:  row_lo_q[0] <= cfg_wdata_i;
        REG_ROW_X_HI:  row_hi_q[0] <= cfg_wdata_i;
        REG_ROW_Y_LO:  row_lo_q[1] <= cfg_wdata_i;
        REG_ROW_Y_HI:  row_hi_q[1] <= cfg_wdata_i;
        REG_ROW_W_LO:  row_lo_q[2] <= cfg_wdata_i;
        REG_ROW_W_HI:  row_hi_q[2] <= cfg_wdata_i;
        REG_VIEWPORT:  viewport_q  <= cfg_wdata_i;
        REG_MIN_DEPTH: min_depth_q <= cfg_wdata_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits and stage enables. A stage loads when it is empty or when
  // everything after it moves; an empty stage anywhere downstream lets it move.
  // --------------------------------------------------------------------------
  logic [N_ST-1:0] v_q;
  logic [N_ST-1:0] en;

  for (genvar k = 0; k < N_ST; k++) begin : g_en
    assign en[k] = m_axis_tready_i || !(&v_q[N_ST-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < N_ST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // --------------------------------------------------------------------------
  // Stage 1: the nine coefficient by coordinate products.
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] world [0:2];
  logic signed [COORD_W-1:0] cf [0:2][0:3];
  logic signed [2*COORD_W-1:0] prod_q [0:2][0:2];

  assign world[0] = $signed(s_axis_tdata_i[COORD_W-1:0]);
  assign world[1] = $signed(s_axis_tdata_i[2*COORD_W-1:COORD_W]);
  assign world[2] = $signed(s_axis_tdata_i[3*COORD_W-1:2*COORD_W]);

  for (genvar r = 0; r < 3; r++) begin : g_cf
    assign cf[r][0] = $signed(row_lo_q[r][31:0]);
    assign cf[r][1] = $signed(row_lo_q[r][63:32]);
    assign cf[r][2] = $signed(row_hi_q[r][31:0]);
    assign cf[r][3] = $signed(row_hi_q[r][63:32]);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= cf[r][c] * world[c];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clip values, floor of the product sum plus the offset column.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  sum_d [0:2];
  logic signed [CLIP_W-1:0] clip_d [0:2];
  logic signed [CLIP_W-1:0] clip_q [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r]  = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
      clip_d[r] = CLIP_W'(sum_d[r] >>> FRAC_BITS) + CLIP_W'(cf[r][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_CLIP]) begin
      for (int r = 0; r < 3; r++) clip_q[r] <= clip_d[r];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: depth test and the four numerator products.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]          vp_left, vp_top, vp_width, vp_height;
  logic [PIX_W:0]            mid_x, mid_y;
  logic signed [PIX_W+2:0]   cxn_s, cyn_s;
  logic signed [PIX_W:0]     width_s, height_s;
  logic signed [CLIP_W-1:0]  min_ext;
  logic                      vis_d;
  logic                      vis3_q;
  logic signed [MUL_W-1:0]   ax_q, bx_q, ay_q, by_q;
  logic signed [CLIP_W-1:0]  cw3_q;

  assign vp_left   = viewport_q[15:0];
  assign vp_top    = viewport_q[31:16];
  assign vp_width  = viewport_q[47:32];
  assign vp_height = viewport_q[63:48];
  assign mid_x     = (PIX_W+1)'(vp_left) + (PIX_W+1)'(vp_width[PIX_W-1:1]);
  assign mid_y     = (PIX_W+1)'(vp_top) + (PIX_W+1)'(vp_height[PIX_W-1:1]);
  assign cxn_s     = $signed({1'b0, mid_x, 1'b1});
  assign cyn_s     = $signed({1'b0, mid_y, 1'b0}) - 19'sd1;
  assign width_s   = $signed({1'b0, vp_width});
  assign height_s  = $signed({1'b0, vp_height});
  assign min_ext   = $signed(CLIP_W'(min_depth_q));
  assign vis_d     = (clip_q[2] > 0) && (clip_q[2] >= min_ext);

  always_ff @(posedge clk_i) begin
    if (en[ST_PROJ]) begin
      vis3_q <= vis_d;
      ax_q   <= clip_q[0] * width_s;
      bx_q   <= clip_q[2] * cxn_s;
      ay_q   <= clip_q[1] * height_s;
      by_q   <= clip_q[2] * cyn_s;
      cw3_q  <= clip_q[2];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: numerators of the two pixel quotients.
  // --------------------------------------------------------------------------
  logic                     vis4_q;
  logic signed [NUM_W-1:0]  nx_q, ny_q;
  logic signed [CLIP_W-1:0] cw4_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      vis4_q <= vis3_q;
      nx_q   <= NUM_W'(bx_q) + NUM_W'(ax_q);
      ny_q   <= NUM_W'(by_q) - NUM_W'(ay_q);
      cw4_q  <= cw3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: sign and magnitude of the numerators; the divisor is 2*w.
  // --------------------------------------------------------------------------
  logic              vis5_q, neg_x5_q, neg_y5_q;
  logic [NUM_W-1:0]  mag_x_q, mag_y_q;
  logic [DEN_W-1:0]  den5_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      vis5_q   <= vis4_q;
      neg_x5_q <= nx_q[NUM_W-1];
      neg_y5_q <= ny_q[NUM_W-1];
      mag_x_q  <= nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
      mag_y_q  <= ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
      den5_q   <= {cw4_q[CLIP_W-2:0], 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: range check. A quotient of 2^16 or more always saturates, so the
  // divider only resolves the low sixteen bits.
  // --------------------------------------------------------------------------
  div_t             div_q [0:QUOT_W];
  logic [NUM_W-1:0] den_top;

  assign den_top = NUM_W'(den5_q) << QUOT_W;

  always_ff @(posedge clk_i) begin
    if (en[ST_RANGE]) begin
      div_q[0].vis   <= vis5_q;
      div_q[0].neg_x <= neg_x5_q;
      div_q[0].neg_y <= neg_y5_q;
      div_q[0].big_x <= mag_x_q >= den_top;
      div_q[0].big_y <= mag_y_q >= den_top;
      div_q[0].den   <= den5_q;
      div_q[0].rem_x <= RW'(mag_x_q);
      div_q[0].rem_y <= RW'(mag_y_q);
      div_q[0].q_x   <= '0;
      div_q[0].q_y   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant first, for both
  // pixel axes against the shared divisor.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    localparam int unsigned B = QUOT_W - 1 - i;
    logic [RW-1:0] dsh;
    logic          hit_x, hit_y;

    assign dsh   = RW'(div_q[i].den) << B;
    assign hit_x = div_q[i].rem_x >= dsh;
    assign hit_y = div_q[i].rem_y >= dsh;

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0 + i]) begin
        div_q[i+1].vis   <= div_q[i].vis;
        div_q[i+1].neg_x <= div_q[i].neg_x;
        div_q[i+1].neg_y <= div_q[i].neg_y;
        div_q[i+1].big_x <= div_q[i].big_x;
        div_q[i+1].big_y <= div_q[i].big_y;
        div_q[i+1].den   <= div_q[i].den;
        div_q[i+1].rem_x <= hit_x ? div_q[i].rem_x - dsh : div_q[i].rem_x;
        div_q[i+1].rem_y <= hit_y ? div_q[i].rem_y - dsh : div_q[i].rem_y;
        div_q[i+1].q_x   <= {div_q[i].q_x[QUOT_W-2:0], hit_x};
        div_q[i+1].q_y   <= {div_q[i].q_y[QUOT_W-2:0], hit_y};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: sign, saturation and culling.
  // --------------------------------------------------------------------------
  logic                    out_vis_q;
  logic signed [PIX_W-1:0] out_x_q, out_y_q;
  div_t                    fin;

  assign fin = div_q[QUOT_W];

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_vis_q <= fin.vis;
      out_x_q   <= fin.vis ? sat_pix(fin.neg_x, fin.big_x, fin.q_x) : '0;
      out_y_q   <= fin.vis ? sat_pix(fin.neg_y, fin.big_y, fin.q_y) : '0;
    end
  end

  assign m_axis_tvalid_o   = v_q[ST_OUT];
  assign m_axis_tdata_o    = {out_y_q, out_x_q};
  assign m_axis_tuser_o[0] = out_vis_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A culled point carries no pixel position.
  a_culled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("culled point carries a nonzero pixel position");

  // The input side only backs up when every stage is full and the output waits.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q) && !m_axis_tready_i)
    else $error("input stalled with room in the pipeline");

  // A visible point enters the divider with a nonzero divisor.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_RANGE] && div_q[0].vis |-> div_q[0].den != '0)
    else $error("visible point with a zero divisor");

endmodule
